// ===== rtl/mqsb_pkg.sv =====
`default_nettype none

package mqsb_pkg;

  // block sizing
  localparam int NUM_QUEUES = 4;
  localparam int SLOTS      = 64;
  localparam int DATA_W     = 32;

  // port field widths, fixed by the interface
  localparam int KIND_W     = 1;
  localparam int QUEUE_ID_W = 2;
  localparam int VALUE_W    = 32;
  localparam int STATUS_W   = 2;

  // derived widths: a pointer also holds the null value SLOTS
  localparam int PTR_W = $clog2(SLOTS + 1);
  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int QID_W = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;

  typedef logic [PTR_W-1:0] ptr_t;

  localparam ptr_t NIL_PTR = PTR_W'(SLOTS);

  localparam logic KIND_ENQ = 1'b0;
  localparam logic KIND_DEQ = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic finish;
  } mqsb_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;
  } mqsb_sts_t;

endpackage

`default_nettype wire

// ===== rtl/mqsb_ctrl.sv =====
`default_nettype none

module mqsb_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  mqsb_pkg::mqsb_sts_t sts,
  output mqsb_pkg::mqsb_cmd_t cmd
);
  import mqsb_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // take an item only when idle and the result register is free or being emptied
  assign in_ready    = (state_r == S_IDLE) && sts.out_free;
  assign cmd.capture = in_valid && in_ready;
  assign cmd.finish  = (state_r == S_EXEC);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (cmd.capture) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/mqsb_dp.sv =====
`default_nettype none

module mqsb_dp (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  mqsb_pkg::mqsb_cmd_t                     cmd,
  output mqsb_pkg::mqsb_sts_t                     sts,
  input  logic [mqsb_pkg::KIND_W-1:0]             in_kind,
  input  logic [mqsb_pkg::QUEUE_ID_W-1:0]         in_queue_id,
  input  logic signed [mqsb_pkg::VALUE_W-1:0]     in_value,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic [mqsb_pkg::STATUS_W-1:0]           out_status,
  output logic signed [mqsb_pkg::VALUE_W-1:0]     out_data_out
);
  import mqsb_pkg::*;

  // slot stores
  logic [DATA_W-1:0] data_mem [SLOTS];
  ptr_t              link_mem [SLOTS];

  // pointer registers
  ptr_t             head_r [NUM_QUEUES];
  logic [IDX_W-1:0] tail_r [NUM_QUEUES];
  ptr_t             free_head_r;
  ptr_t             fill_r;        // slots at or above this were never touched

  // per-item registers
  logic             kind_r;
  logic [QID_W-1:0] q_r;
  ptr_t             slot_r;
  logic             fail_r;
  logic             fresh_r;
  ptr_t             link_rd_r;
  logic [DATA_W-1:0] data_rd_r;

  // result register
  logic              out_valid_r;
  status_t           out_status_r;
  logic [VALUE_W-1:0] out_data_r;

  logic             q_now;
  logic [QID_W-1:0] qid_now;
  ptr_t             slot_now;
  logic             fail_now;
  logic             link_we;
  logic [IDX_W-1:0] link_waddr;
  ptr_t             link_wdata;
  ptr_t             next_link;
  status_t          status_nxt;
  logic [63:0]      data_wide;

  assign qid_now  = QID_W'(32'(in_queue_id) % NUM_QUEUES);
  assign q_now    = (in_kind == KIND_DEQ);
  assign slot_now = q_now ? head_r[qid_now] : free_head_r;
  assign fail_now = (slot_now == NIL_PTR);

  // untouched slots still chain to the next one
  assign next_link = fresh_r ? (slot_r + PTR_W'(1)) : link_rd_r;

  // link writes: tail relink at capture, slot relink at finish
  always_comb begin
    link_we    = 1'b0;
    link_waddr = tail_r[qid_now];
    link_wdata = free_head_r;
    if (cmd.capture && !fail_now && !q_now && (head_r[qid_now] != NIL_PTR)) begin
      link_we = 1'b1;
    end else if (cmd.finish && !fail_r) begin
      link_we    = 1'b1;
      link_waddr = slot_r[IDX_W-1:0];
      link_wdata = (kind_r == KIND_ENQ) ? NIL_PTR : free_head_r;
    end
  end

  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    if (cmd.capture && !fail_now) begin
      link_rd_r <= link_mem[slot_now[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture && !fail_now && !q_now) begin
      data_mem[slot_now[IDX_W-1:0]] <= DATA_W'($unsigned(in_value));
    end
    if (cmd.capture && !fail_now && q_now) begin
      data_rd_r <= data_mem[slot_now[IDX_W-1:0]];
    end
  end

  // item capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r  <= q_now;
      q_r     <= qid_now;
      slot_r  <= slot_now;
      fail_r  <= fail_now;
      fresh_r <= (slot_now >= fill_r);
    end
  end

  // pointer updates
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_QUEUES; i++) begin
        head_r[i] <= NIL_PTR;
      end
      free_head_r <= '0;
      fill_r      <= '0;
    end else if (cmd.finish && !fail_r) begin
      if (kind_r == KIND_ENQ) begin
        free_head_r <= next_link;
        if (head_r[q_r] == NIL_PTR) begin
          head_r[q_r] <= slot_r;
        end
        if (fresh_r) begin
          fill_r <= fill_r + PTR_W'(1);
        end
      end else begin
        head_r[q_r] <= next_link;
        free_head_r <= slot_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish && !fail_r && (kind_r == KIND_ENQ)) begin
      tail_r[q_r] <= slot_r[IDX_W-1:0];
    end
  end

  // result
  always_comb begin
    status_nxt = ST_DONE;
    if (fail_r) begin
      status_nxt = (kind_r == KIND_ENQ) ? ST_FULL : ST_EMPTY;
    end
  end

  assign data_wide = 64'(data_rd_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_status_r <= status_nxt;
      out_data_r   <= (!fail_r && (kind_r == KIND_DEQ)) ? data_wide[VALUE_W-1:0]
                                                        : '0;
    end
  end

  assign sts.out_free  = !out_valid_r || out_ready;

  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_data_out = $signed(out_data_r);

endmodule

`default_nettype wire

// ===== rtl/multi_queue_shared_buffer_top.sv =====
// multi_queue_shared_buffer_top
// several fifo queues sharing one slot store, each queue a linked list of
// slots, unused slots kept on a free list
// input channel: in_valid/in_ready with in_kind (0 enqueue, 1 dequeue),
//   in_queue_id and in_value (word to store, ignored on a dequeue)
// result channel: out_valid/out_ready with out_status (0 done, 1 full,
//   2 empty) and out_data_out (dequeued word, zero otherwise)
// every item yields exactly one result item, in order
// the accepted item is registered, then the execute state writes its result
// no new item is taken until the last one is finished; the pointer walk
//   needs one registered read of the link store followed by its write-back
// a finished result sits in an output register; while the receiver stalls
//   that register holds and no new item is taken until it is emptied
//   (an item is taken in the same cycle the waiting result leaves)
// reset (rst_n low, synchronous): all queues empty, free list holds every
//   slot in order; no clearing pass, the block is ready as soon as reset
//   ends since untouched slots are tracked with a fill count
`default_nettype none

module multi_queue_shared_buffer_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [mqsb_pkg::KIND_W-1:0]         in_kind,
  input  logic [mqsb_pkg::QUEUE_ID_W-1:0]     in_queue_id,
  input  logic signed [mqsb_pkg::VALUE_W-1:0] in_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [mqsb_pkg::STATUS_W-1:0]       out_status,
  output logic signed [mqsb_pkg::VALUE_W-1:0] out_data_out
);
  import mqsb_pkg::*;

  mqsb_cmd_t cmd;
  mqsb_sts_t sts;

  // sequencer: idle / execute
  mqsb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // slot stores, queue pointers and result register
  mqsb_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .in_kind      (in_kind),
    .in_queue_id  (in_queue_id),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_status   (out_status),
    .out_data_out (out_data_out)
  );

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mqsb_pkg::*;

  // run length
  localparam int TOTAL_ITEMS = 1650;
  // last stretch with no idling on either side
  localparam int CALM_ITEMS  = 150;
  // long receiver hold-off, starts once this many items went in
  localparam int HOLD_AT     = 700;
  localparam int HOLD_CYCLES = 300;
  localparam int MAX_REPORTS = 10;

  // one row of the directed script; typed rows carry their own expected result
  typedef struct {
    logic                kind;
    logic [QUEUE_ID_W-1:0] qid;
    logic [VALUE_W-1:0]  value;
    bit                  typed;
    status_t             st;
    logic [VALUE_W-1:0]  data;
  } op_row_t;

  // what one result item should carry
  typedef struct {
    status_t            st;
    logic [VALUE_W-1:0] data;
  } queue_result_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic [KIND_W-1:0]          in_kind = '0;
  logic [QUEUE_ID_W-1:0]      in_queue_id = '0;
  logic signed [VALUE_W-1:0]  in_value = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic [STATUS_W-1:0]        out_status;
  logic signed [VALUE_W-1:0]  out_data_out;

  multi_queue_shared_buffer_top DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_kind      (in_kind),
    .in_queue_id  (in_queue_id),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_status   (out_status),
    .out_data_out (out_data_out)
  );

  // shadow copy of the slot store, the link store and the list pointers
  logic [DATA_W-1:0] slot_word [SLOTS];
  ptr_t              slot_next [SLOTS];
  ptr_t              q_head    [NUM_QUEUES];
  ptr_t              q_tail    [NUM_QUEUES];
  ptr_t              free_ptr;

  queue_result_t pending_results [$];
  int            items_sent = 0;
  int            mismatch_cnt = 0;
  bit            long_hold_done = 1'b0;

  // directed script: empty dequeues after reset, extreme words in and out in
  // order, slot reuse through the free list, empty again at the end
  op_row_t script [21] = '{
    '{KIND_DEQ, 2'd0, 32'h0000_0000, 1'b1, ST_EMPTY, 32'h0000_0000},
    '{KIND_DEQ, 2'd1, 32'hFFFF_FFFF, 1'b1, ST_EMPTY, 32'h0000_0000},
    '{KIND_DEQ, 2'd2, 32'h1234_5678, 1'b1, ST_EMPTY, 32'h0000_0000},
    '{KIND_DEQ, 2'd3, 32'h0000_0000, 1'b1, ST_EMPTY, 32'h0000_0000},
    '{KIND_ENQ, 2'd0, 32'h8000_0000, 1'b1, ST_DONE,  32'h0000_0000},
    '{KIND_ENQ, 2'd0, 32'h7FFF_FFFF, 1'b1, ST_DONE,  32'h0000_0000},
    '{KIND_ENQ, 2'd3, 32'h0000_0000, 1'b1, ST_DONE,  32'h0000_0000},
    '{KIND_ENQ, 2'd3, 32'hFFFF_FFFF, 1'b1, ST_DONE,  32'h0000_0000},
    '{KIND_ENQ, 2'd1, 32'h5555_5555, 1'b0, ST_DONE,  32'h0000_0000},
    '{KIND_ENQ, 2'd2, 32'hAAAA_AAAA, 1'b0, ST_DONE,  32'h0000_0000},
    '{KIND_DEQ, 2'd0, 32'hFFFF_FFFF, 1'b1, ST_DONE,  32'h8000_0000},
    '{KIND_DEQ, 2'd3, 32'h0000_0000, 1'b1, ST_DONE,  32'h0000_0000},
    '{KIND_DEQ, 2'd0, 32'h0000_0000, 1'b1, ST_DONE,  32'h7FFF_FFFF},
    '{KIND_DEQ, 2'd0, 32'h0000_0000, 1'b1, ST_EMPTY, 32'h0000_0000},
    '{KIND_DEQ, 2'd3, 32'h0000_0000, 1'b1, ST_DONE,  32'hFFFF_FFFF},
    '{KIND_DEQ, 2'd2, 32'h0000_0000, 1'b0, ST_DONE,  32'h0000_0000},
    '{KIND_ENQ, 2'd1, 32'h0000_1234, 1'b0, ST_DONE,  32'h0000_0000},
    '{KIND_DEQ, 2'd1, 32'h0000_0000, 1'b0, ST_DONE,  32'h0000_0000},
    '{KIND_DEQ, 2'd1, 32'h0000_0000, 1'b0, ST_DONE,  32'h0000_0000},
    '{KIND_DEQ, 2'd1, 32'h0000_0000, 1'b1, ST_EMPTY, 32'h0000_0000},
    '{KIND_DEQ, 2'd2, 32'h0000_0000, 1'b1, ST_EMPTY, 32'h0000_0000}
  };

  // free list chains every slot in order, all queues empty
  function automatic void clear_queues();
    for (int i = 0; i < SLOTS; i++) begin
      slot_word[i] = '0;
      slot_next[i] = (i == SLOTS - 1) ? NIL_PTR : ptr_t'(i + 1);
    end
    for (int i = 0; i < NUM_QUEUES; i++) begin
      q_head[i] = NIL_PTR;
      q_tail[i] = '0;
    end
    free_ptr = '0;
  endfunction

  // one queue operation applied to the shadow lists
  function automatic queue_result_t apply_queue_op(input logic kind,
                                                   input logic [QUEUE_ID_W-1:0] qid,
                                                   input logic [VALUE_W-1:0] word);
    queue_result_t res;
    int unsigned   q;
    ptr_t          s;
    q = qid % NUM_QUEUES;
    res.st = ST_DONE;
    res.data = '0;
    if (kind == KIND_ENQ) begin
      if (free_ptr == NIL_PTR) begin
        res.st = ST_FULL;
      end else begin
        s = free_ptr;
        slot_word[s] = word[DATA_W-1:0];
        free_ptr = slot_next[s];
        // first entry becomes the head, otherwise it hangs off the tail
        if (q_head[q] == NIL_PTR) begin
          q_head[q] = s;
        end else begin
          slot_next[q_tail[q]] = s;
        end
        slot_next[s] = NIL_PTR;
        q_tail[q] = s;
      end
    end else begin
      if (q_head[q] == NIL_PTR) begin
        res.st = ST_EMPTY;
      end else begin
        // unlink the head and push its slot back on the front of the free list
        s = q_head[q];
        q_head[q] = slot_next[s];
        slot_next[s] = free_ptr;
        free_ptr = s;
        res.data = VALUE_W'(slot_word[s]);
      end
    end
    return res;
  endfunction

  function automatic bit calm_phase();
    return items_sent >= TOTAL_ITEMS - CALM_ITEMS;
  endfunction

  // offer one item, hold it until taken, then record what it should yield
  task automatic push_item(input op_row_t row);
    queue_result_t res;
    int            gap;
    // now and then a random sender gap, outside the calm stretch
    if (!calm_phase() && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_kind     <= row.kind;
    in_queue_id <= row.qid;
    in_value    <= row.value;
    do @(posedge clk); while (!in_ready);
    // taken at this edge: the shadow state moves on even for typed rows
    res = apply_queue_op(row.kind, row.qid, row.value);
    if (row.typed) begin
      res.st = row.st;
      res.data = row.data;
    end
    pending_results.push_back(res);
    items_sent++;
  endtask

  // mostly random words, now and then an extreme one
  function automatic logic [VALUE_W-1:0] pick_word();
    case ($urandom_range(0, 11))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // clock, 20 ns period
  initial begin
    forever #10 clk = ~clk;
  end

  // hard stop in case the block hangs
  initial begin
    #3_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // result side: check each taken result, then pick ready for the next cycle
  initial begin
    queue_result_t want;
    int            stall_left;
    stall_left = 0;
    while (!rst_n) @(posedge clk);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= MAX_REPORTS)
            $display("result with nothing pending: status %0d data %h",
                     out_status, out_data_out);
        end else begin
          want = pending_results.pop_front();
          if (out_status !== want.st || out_data_out !== want.data) begin
            mismatch_cnt++;
            if (mismatch_cnt <= MAX_REPORTS)
              $display("result mismatch: status exp %0d got %0d, data exp %h got %h",
                       want.st, out_status, want.data, out_data_out);
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (!long_hold_done && items_sent >= HOLD_AT) begin
        // long hold-off: output register fills, input stalls behind it
        long_hold_done = 1'b1;
        stall_left = HOLD_CYCLES - 1;
        out_ready <= 1'b0;
      end else if (!calm_phase() && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 6) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // stimulus
  initial begin
    op_row_t row;
    int      phase_len;
    int      enq_pct;
    bit      focus;
    logic [QUEUE_ID_W-1:0] focus_q;
    bit      first_phase;

    clear_queues();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (script[i]) push_item(script[i]);

    // random part in phases: the first fills the store past full, later ones
    // lean toward enqueue, toward dequeue or stay balanced so the lists grow and drain repeatedly
    first_phase = 1'b1;
    while (items_sent < TOTAL_ITEMS) begin
      if (first_phase) begin
        phase_len = SLOTS + 8;
        enq_pct = 100;
        first_phase = 1'b0;
      end else begin
        phase_len = $urandom_range(20, 90);
        case ($urandom_range(0, 3))
          0:       enq_pct = 90;
          1:       enq_pct = 15;
          default: enq_pct = 55;
        endcase
      end
      focus = ($urandom_range(0, 3) == 0);
      focus_q = QUEUE_ID_W'($urandom_range(0, NUM_QUEUES - 1));
      for (int n = 0; n < phase_len && items_sent < TOTAL_ITEMS; n++) begin
        row.kind = ($urandom_range(0, 99) < enq_pct) ? KIND_ENQ : KIND_DEQ;
        row.qid = focus ? focus_q : QUEUE_ID_W'($urandom_range(0, 3));
        row.value = pick_word();
        row.typed = 1'b0;
        row.st = ST_DONE;
        row.data = '0;
        push_item(row);
      end
    end
    in_valid <= 1'b0;

    // drain, then keep watching for any stray result before the verdict
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

`default_nettype wire
